[rtl/segment_intersection_point_core_macros.svh]
// Assertion macros for the segment intersection point core
`ifndef SEGMENT_INTERSECTION_POINT_CORE_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_CORE_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define SIP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sip assertion failed");

// Condition that must hold in the first cycle after reset was released
`define SIP_ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) ($past(reset) && !reset) |-> (cons)) \
      else $error("sip reset assertion failed");

`endif

[rtl/sip_pkg.sv]
package sip_pkg;

   // default coordinate width
   localparam int COORD_WIDTH_DEF = 16;

   // per-item flags carried down the divider chain
   typedef struct packed {
      logic overlap;
      logic den_zero;
      logic neg_x;
      logic neg_y;
   } sip_flag_type;

endpackage

[rtl/segment_intersection_point_core.sv]
// channel | ports                                   | direction
// req     | req_valid/req_ready, eight coordinates  | in
// rsp     | rsp_valid/rsp_ready, hit, point, flags  | out
//
// One item per cycle sustained while rsp_ready is held high.
// The pipeline is six front stages (products, sums, magnitudes), a chain of
// COORD_WIDTH + 2 divider cells (one quotient bit each) and the result register.
// Reset clears all valid bits; no item is in flight after reset.
// A stalled result holds the result register; earlier stages keep filling
// bubbles, so new items are accepted until the chain is full.

`include "segment_intersection_point_core_macros.svh"

module segment_intersection_point_core #(
   parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_a_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic                          rsp_point_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y
);

   localparam int W  = COORD_WIDTH;
   localparam int QW = W+1;
   localparam int NC = QW+1;
   localparam int PW = 3*W+5;
   localparam int DW = 2*W+3;

   // links between front, cells and result stage
   logic                  v_s   [NC+1];
   logic                  r_s   [NC+1];
   logic [PW-1:0]         rx_s  [NC+1];
   logic [PW-1:0]         ry_s  [NC+1];
   logic [QW:0]           qx_s  [NC+1];
   logic [QW:0]           qy_s  [NC+1];
   logic [DW-1:0]         d_s   [NC+1];
   logic [8*W-1:0]        crd_s [NC+1];
   sip_pkg::sip_flag_type flg_s [NC+1];

   sip_front #(.COORD_WIDTH(W)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_a_start_x (req_a_start_x),
      .req_a_start_y (req_a_start_y),
      .req_a_end_x   (req_a_end_x),
      .req_a_end_y   (req_a_end_y),
      .req_b_start_x (req_b_start_x),
      .req_b_start_y (req_b_start_y),
      .req_b_end_x   (req_b_end_x),
      .req_b_end_y   (req_b_end_y),
      .dn_valid      (v_s[0]),
      .dn_ready      (r_s[0]),
      .dn_rem_x      (rx_s[0]),
      .dn_rem_y      (ry_s[0]),
      .dn_d          (d_s[0]),
      .dn_crd        (crd_s[0]),
      .dn_flag       (flg_s[0])
   );

   assign qx_s[0] = '0;
   assign qy_s[0] = '0;

   // divider chain, most significant quotient bit first
   for (genvar k = 0; k < NC; k++) begin : g_cell
      sip_cell #(.COORD_WIDTH(W), .STEP(QW-k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (v_s[k]),
         .up_ready (r_s[k]),
         .up_rem_x (rx_s[k]),
         .up_rem_y (ry_s[k]),
         .up_q_x   (qx_s[k]),
         .up_q_y   (qy_s[k]),
         .up_d     (d_s[k]),
         .up_crd   (crd_s[k]),
         .up_flag  (flg_s[k]),
         .dn_valid (v_s[k+1]),
         .dn_ready (r_s[k+1]),
         .dn_rem_x (rx_s[k+1]),
         .dn_rem_y (ry_s[k+1]),
         .dn_q_x   (qx_s[k+1]),
         .dn_q_y   (qy_s[k+1]),
         .dn_d     (d_s[k+1]),
         .dn_crd   (crd_s[k+1]),
         .dn_flag  (flg_s[k+1])
      );
   end

   sip_out #(.COORD_WIDTH(W)) u_out (
      .clock           (clock),
      .reset           (reset),
      .up_valid        (v_s[NC]),
      .up_ready        (r_s[NC]),
      .up_q_x          (qx_s[NC]),
      .up_q_y          (qy_s[NC]),
      .up_crd          (crd_s[NC]),
      .up_flag         (flg_s[NC]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_point_valid (rsp_point_valid),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y)
   );

   // disjoint boxes give an all-zero result
   `SIP_ASSERT_IMP(a_disjoint_zero, rsp_valid && !rsp_point_valid, !rsp_hit && rsp_point_x == '0 && rsp_point_y == '0)
   // a hit needs a computed point
   `SIP_ASSERT_IMP(a_hit_computed, rsp_valid && rsp_hit, rsp_point_valid)
   // nothing in flight right after reset
   `SIP_ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid && !v_s[0])

endmodule

[rtl/sip_front.sv]
module sip_front #(
   parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [COORD_WIDTH-1:0]        req_a_start_x,
   input  logic signed [COORD_WIDTH-1:0]        req_a_start_y,
   input  logic signed [COORD_WIDTH-1:0]        req_a_end_x,
   input  logic signed [COORD_WIDTH-1:0]        req_a_end_y,
   input  logic signed [COORD_WIDTH-1:0]        req_b_start_x,
   input  logic signed [COORD_WIDTH-1:0]        req_b_start_y,
   input  logic signed [COORD_WIDTH-1:0]        req_b_end_x,
   input  logic signed [COORD_WIDTH-1:0]        req_b_end_y,
   output logic                                 dn_valid,
   input  logic                                 dn_ready,
   output logic [3*COORD_WIDTH+4:0]             dn_rem_x,
   output logic [3*COORD_WIDTH+4:0]             dn_rem_y,
   output logic [2*COORD_WIDTH+2:0]             dn_d,
   output logic [8*COORD_WIDTH-1:0]             dn_crd,
   output sip_pkg::sip_flag_type                dn_flag
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = 2*W+3;
   localparam int NW = 2*W+3;
   localparam int MW = 2*W+2;
   localparam int PW = 3*W+5;

   // stage valids and advance terms
   logic v_a_ff, v_b_ff, v_c_ff, v_d_ff, v_e_ff, v_f_ff;
   logic adv_a, adv_b, adv_c, adv_d, adv_e, adv_f;

   assign adv_f = !v_f_ff || dn_ready;
   assign adv_e = !v_e_ff || adv_f;
   assign adv_d = !v_d_ff || adv_e;
   assign adv_c = !v_c_ff || adv_d;
   assign adv_b = !v_b_ff || adv_c;
   assign adv_a = !v_a_ff || adv_b;
   assign req_ready = adv_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
         v_e_ff <= 1'b0;
         v_f_ff <= 1'b0;
      end else begin
         if (adv_a) v_a_ff <= req_valid;
         if (adv_b) v_b_ff <= v_a_ff;
         if (adv_c) v_c_ff <= v_b_ff;
         if (adv_d) v_d_ff <= v_c_ff;
         if (adv_e) v_e_ff <= v_d_ff;
         if (adv_f) v_f_ff <= v_e_ff;
      end
   end

   // stage A: capture item
   logic [8*W-1:0] crd_a_ff;
   always_ff @(posedge clock) begin
      if (adv_a) begin
         crd_a_ff <= {req_b_end_y, req_b_end_x, req_b_start_y, req_b_start_x,
                      req_a_end_y, req_a_end_x, req_a_start_y, req_a_start_x};
      end
   end

   logic signed [W-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
   assign asx = crd_a_ff[0*W +: W];
   assign asy = crd_a_ff[1*W +: W];
   assign aex = crd_a_ff[2*W +: W];
   assign aey = crd_a_ff[3*W +: W];
   assign bsx = crd_a_ff[4*W +: W];
   assign bsy = crd_a_ff[5*W +: W];
   assign bex = crd_a_ff[6*W +: W];
   assign bey = crd_a_ff[7*W +: W];

   // stage B: extents, box overlap, cross products
   logic signed [W:0] adx, ady, bdx, bdy;
   assign adx = (W+1)'(aex) - (W+1)'(asx);
   assign ady = (W+1)'(aey) - (W+1)'(asy);
   assign bdx = (W+1)'(bex) - (W+1)'(bsx);
   assign bdy = (W+1)'(bey) - (W+1)'(bsy);

   logic signed [W-1:0] amax_x, amin_x, amax_y, amin_y;
   logic signed [W-1:0] bmax_x, bmin_x, bmax_y, bmin_y;
   logic                ovl;
   assign amax_x = (asx > aex) ? asx : aex;
   assign amin_x = (asx < aex) ? asx : aex;
   assign amax_y = (asy > aey) ? asy : aey;
   assign amin_y = (asy < aey) ? asy : aey;
   assign bmax_x = (bsx > bex) ? bsx : bex;
   assign bmin_x = (bsx < bex) ? bsx : bex;
   assign bmax_y = (bsy > bey) ? bsy : bey;
   assign bmin_y = (bsy < bey) ? bsy : bey;
   assign ovl = !((amax_x < bmin_x) || (amin_x > bmax_x) ||
                  (amax_y < bmin_y) || (amin_y > bmax_y));

   logic signed [MW-1:0] m1_ff, m2_ff, n1_ff, n2_ff, n3_ff, n4_ff;
   logic signed [W:0]    bdx_b_ff, bdy_b_ff;
   logic [8*W-1:0]       crd_b_ff;
   logic                 ovl_b_ff;
   always_ff @(posedge clock) begin
      if (adv_b) begin
         m1_ff    <= MW'(bdx) * MW'(ady);
         m2_ff    <= MW'(bdy) * MW'(adx);
         n1_ff    <= MW'(asx) * MW'(aey);
         n2_ff    <= MW'(asy) * MW'(aex);
         n3_ff    <= MW'(bsx) * MW'(ady);
         n4_ff    <= MW'(bsy) * MW'(adx);
         bdx_b_ff <= bdx;
         bdy_b_ff <= bdy;
         crd_b_ff <= crd_a_ff;
         ovl_b_ff <= ovl;
      end
   end

   // stage C: denominator and numerator
   logic signed [DW-1:0] den_c_ff;
   logic signed [NW-1:0] num_c_ff;
   logic signed [W:0]    bdx_c_ff, bdy_c_ff;
   logic [8*W-1:0]       crd_c_ff;
   logic                 ovl_c_ff;
   always_ff @(posedge clock) begin
      if (adv_c) begin
         den_c_ff <= DW'(m1_ff) - DW'(m2_ff);
         num_c_ff <= NW'(n1_ff) - NW'(n2_ff) - NW'(n3_ff) + NW'(n4_ff);
         bdx_c_ff <= bdx_b_ff;
         bdy_c_ff <= bdy_b_ff;
         crd_c_ff <= crd_b_ff;
         ovl_c_ff <= ovl_b_ff;
      end
   end

   // stage D: dividend partial products
   logic signed [W-1:0]  bsx_c, bsy_c;
   assign bsx_c = crd_c_ff[4*W +: W];
   assign bsy_c = crd_c_ff[5*W +: W];

   logic signed [PW-1:0] px1_ff, px2_ff, py1_ff, py2_ff;
   logic signed [DW-1:0] den_d_ff;
   logic [8*W-1:0]       crd_d_ff;
   logic                 ovl_d_ff;
   always_ff @(posedge clock) begin
      if (adv_d) begin
         px1_ff   <= PW'(bsx_c) * PW'(den_c_ff);
         px2_ff   <= PW'(num_c_ff) * PW'(bdx_c_ff);
         py1_ff   <= PW'(bsy_c) * PW'(den_c_ff);
         py2_ff   <= PW'(num_c_ff) * PW'(bdy_c_ff);
         den_d_ff <= den_c_ff;
         crd_d_ff <= crd_c_ff;
         ovl_d_ff <= ovl_c_ff;
      end
   end

   // stage E: dividends
   logic signed [PW-1:0] sx_ff, sy_ff;
   logic signed [DW-1:0] den_e_ff;
   logic [8*W-1:0]       crd_e_ff;
   logic                 ovl_e_ff;
   always_ff @(posedge clock) begin
      if (adv_e) begin
         sx_ff    <= px1_ff + px2_ff;
         sy_ff    <= py1_ff + py2_ff;
         den_e_ff <= den_d_ff;
         crd_e_ff <= crd_d_ff;
         ovl_e_ff <= ovl_d_ff;
      end
   end

   // stage F: magnitudes and quotient signs
   logic [PW-1:0] mag_x, mag_y;
   logic [DW-1:0] mag_d;
   assign mag_x = sx_ff[PW-1] ? PW'(-sx_ff) : PW'(sx_ff);
   assign mag_y = sy_ff[PW-1] ? PW'(-sy_ff) : PW'(sy_ff);
   assign mag_d = den_e_ff[DW-1] ? DW'(-den_e_ff) : DW'(den_e_ff);

   sip_pkg::sip_flag_type flag_in;
   always_comb begin
      flag_in.overlap  = ovl_e_ff;
      flag_in.den_zero = (den_e_ff == '0);
      flag_in.neg_x    = sx_ff[PW-1] ^ den_e_ff[DW-1];
      flag_in.neg_y    = sy_ff[PW-1] ^ den_e_ff[DW-1];
   end

   always_ff @(posedge clock) begin
      if (adv_f) begin
         dn_rem_x <= mag_x;
         dn_rem_y <= mag_y;
         dn_d     <= mag_d;
         dn_crd   <= crd_e_ff;
         dn_flag  <= flag_in;
      end
   end

   assign dn_valid = v_f_ff;

endmodule

[rtl/sip_cell.sv]
module sip_cell #(
   parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF,
   parameter int STEP        = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  logic [3*COORD_WIDTH+4:0]  up_rem_x,
   input  logic [3*COORD_WIDTH+4:0]  up_rem_y,
   input  logic [COORD_WIDTH+1:0]    up_q_x,
   input  logic [COORD_WIDTH+1:0]    up_q_y,
   input  logic [2*COORD_WIDTH+2:0]  up_d,
   input  logic [8*COORD_WIDTH-1:0]  up_crd,
   input  sip_pkg::sip_flag_type     up_flag,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output logic [3*COORD_WIDTH+4:0]  dn_rem_x,
   output logic [3*COORD_WIDTH+4:0]  dn_rem_y,
   output logic [COORD_WIDTH+1:0]    dn_q_x,
   output logic [COORD_WIDTH+1:0]    dn_q_y,
   output logic [2*COORD_WIDTH+2:0]  dn_d,
   output logic [8*COORD_WIDTH-1:0]  dn_crd,
   output sip_pkg::sip_flag_type     dn_flag
);

   localparam int PW = 3*COORD_WIDTH+5;

   logic                   valid_ff;
   logic                   adv;
   logic [PW-1:0]          dsh;
   logic                   take_x, take_y;
   logic [COORD_WIDTH+1:0] q_x_in, q_y_in;

   assign adv      = !valid_ff || dn_ready;
   assign up_ready = adv;
   assign dn_valid = valid_ff;

   // divisor aligned to this cell's quotient bit
   assign dsh    = PW'(up_d) << STEP;
   assign take_x = (up_rem_x >= dsh);
   assign take_y = (up_rem_y >= dsh);

   // quotient with this cell's bit filled in
   always_comb begin
      q_x_in       = up_q_x;
      q_y_in       = up_q_y;
      q_x_in[STEP] = take_x;
      q_y_in[STEP] = take_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= up_valid;
      end
   end

   // one restoring step for both coordinates
   always_ff @(posedge clock) begin
      if (adv) begin
         dn_rem_x <= take_x ? (up_rem_x - dsh) : up_rem_x;
         dn_rem_y <= take_y ? (up_rem_y - dsh) : up_rem_y;
         dn_q_x   <= q_x_in;
         dn_q_y   <= q_y_in;
         dn_d     <= up_d;
         dn_crd   <= up_crd;
         dn_flag  <= up_flag;
      end
   end

endmodule

[rtl/sip_out.sv]
module sip_out #(
   parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic [COORD_WIDTH+1:0]        up_q_x,
   input  logic [COORD_WIDTH+1:0]        up_q_y,
   input  logic [8*COORD_WIDTH-1:0]      up_crd,
   input  sip_pkg::sip_flag_type         up_flag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic                          rsp_point_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y
);

   localparam int W  = COORD_WIDTH;
   localparam int QW = W+1;

   localparam logic [QW-1:0]        LIM_POS = QW'((1 << (W-1)) - 1);
   localparam logic [QW-1:0]        LIM_NEG = QW'(1 << (W-1));
   localparam logic signed [W-1:0]  SAT_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  SAT_NEG = {1'b1, {(W-1){1'b0}}};

   logic valid_ff;
   logic adv;

   assign adv       = !valid_ff || rsp_ready;
   assign up_ready  = adv;
   assign rsp_valid = valid_ff;

   logic signed [W-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
   assign asx = up_crd[0*W +: W];
   assign asy = up_crd[1*W +: W];
   assign aex = up_crd[2*W +: W];
   assign aey = up_crd[3*W +: W];
   assign bsx = up_crd[4*W +: W];
   assign bsy = up_crd[5*W +: W];
   assign bex = up_crd[6*W +: W];
   assign bey = up_crd[7*W +: W];

   // saturation check and signed quotient
   logic                over_x, over_y, over;
   logic [QW-1:0]       negq_x, negq_y;
   logic signed [W-1:0] px, py;

   assign over_x = !up_flag.den_zero && (up_q_x[QW] ||
                   (up_q_x[QW-1:0] > (up_flag.neg_x ? LIM_NEG : LIM_POS)));
   assign over_y = !up_flag.den_zero && (up_q_y[QW] ||
                   (up_q_y[QW-1:0] > (up_flag.neg_y ? LIM_NEG : LIM_POS)));
   assign over   = over_x || over_y;
   assign negq_x = -up_q_x[QW-1:0];
   assign negq_y = -up_q_y[QW-1:0];

   always_comb begin
      if (up_flag.den_zero) begin
         px = bsx;
      end else if (over_x) begin
         px = up_flag.neg_x ? SAT_NEG : SAT_POS;
      end else begin
         px = up_flag.neg_x ? negq_x[W-1:0] : up_q_x[W-1:0];
      end
   end

   always_comb begin
      if (up_flag.den_zero) begin
         py = bsy;
      end else if (over_y) begin
         py = up_flag.neg_y ? SAT_NEG : SAT_POS;
      end else begin
         py = up_flag.neg_y ? negq_y[W-1:0] : up_q_y[W-1:0];
      end
   end

   // span tests, endpoints included
   logic span_ax, span_bx, span_ay, span_by, hit;
   assign span_ax = ((asx < aex) ? (px >= asx && px <= aex) : (px >= aex && px <= asx));
   assign span_bx = ((bsx < bex) ? (px >= bsx && px <= bex) : (px >= bex && px <= bsx));
   assign span_ay = ((asy < aey) ? (py >= asy && py <= aey) : (py >= aey && py <= asy));
   assign span_by = ((bsy < bey) ? (py >= bsy && py <= bey) : (py >= bey && py <= bsy));
   assign hit = !over && span_ax && span_bx && span_ay && span_by;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= up_valid;
      end
   end

   // result register; zero point when boxes are disjoint
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit         <= up_flag.overlap && hit;
         rsp_point_valid <= up_flag.overlap;
         rsp_point_x     <= up_flag.overlap ? px : '0;
         rsp_point_y     <= up_flag.overlap ? py : '0;
      end
   end

endmodule

[test/segment_intersection_point_core_test.sv]
`timescale 1ns / 100ps

module segment_intersection_point_core_test;

   localparam int CW = sip_pkg::COORD_WIDTH_DEF;
   localparam int ITEM_COUNT = 950;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = CW + 20;

   typedef logic signed [CW-1:0] coord_t;

   typedef struct {
      coord_t asx, asy, aex, aey, bsx, bsy, bex, bey;
   } seg_pair_t;

   typedef struct {
      logic   hit;
      logic   point_valid;
      coord_t px;
      coord_t py;
   } crossing_t;

   // Computes the crossing of two segments and holds expected crossings in order
   class crossing_board;
      crossing_t pending[$];
      int        mismatches;

      // trunc((base*den + num*delta)/den), saturated to the coordinate range
      function automatic longint solve_axis(longint base, longint num, longint delta,
                                            longint den, ref bit over);
         logic signed [127:0] prod;
         logic signed [127:0] quo;
         longint              max_c;
         longint              min_c;
         prod = 128'(base) * 128'(den) + 128'(num) * 128'(delta);
         quo = prod / 128'(den);   // SV division truncates toward zero
         max_c = (64'sd1 <<< (CW - 1)) - 1;
         min_c = -(64'sd1 <<< (CW - 1));
         if (quo > 128'(max_c)) begin
            over = 1;
            return max_c;
         end
         if (quo < 128'(min_c)) begin
            over = 1;
            return min_c;
         end
         return longint'(quo);
      endfunction

      function automatic bit in_span(longint v, longint e1, longint e2);
         return (v >= ((e1 < e2) ? e1 : e2)) && (v <= ((e1 < e2) ? e2 : e1));
      endfunction

      function automatic crossing_t compute(seg_pair_t s);
         crossing_t r;
         longint    asx, asy, aex, aey, bsx, bsy, bex, bey;
         longint    adx, ady, bdx, bdy, den, num, px, py;
         bit        over;
         asx = s.asx; asy = s.asy; aex = s.aex; aey = s.aey;
         bsx = s.bsx; bsy = s.bsy; bex = s.bex; bey = s.bey;
         adx = aex - asx; ady = aey - asy; bdx = bex - bsx; bdy = bey - bsy;
         r = '{0, 0, '0, '0};
         over = 0;
         // bounding boxes apart: nothing computed
         if (((asx > aex) ? asx : aex) < ((bsx < bex) ? bsx : bex) ||
             ((asx < aex) ? asx : aex) > ((bsx > bex) ? bsx : bex) ||
             ((asy > aey) ? asy : aey) < ((bsy < bey) ? bsy : bey) ||
             ((asy < aey) ? asy : aey) > ((bsy > bey) ? bsy : bey))
            return r;
         den = bdx * ady - bdy * adx;
         if (den != 0) begin
            num = asx * aey - asy * aex - bsx * ady + bsy * adx;
            px = solve_axis(bsx, num, bdx, den, over);
            py = solve_axis(bsy, num, bdy, den, over);
         end else begin
            px = bsx;
            py = bsy;
         end
         r.hit = !over && in_span(px, asx, aex) && in_span(px, bsx, bex) &&
                 in_span(py, asy, aey) && in_span(py, bsy, bey);
         r.point_valid = 1;
         r.px = coord_t'(px);
         r.py = coord_t'(py);
         return r;
      endfunction

      function void note_pair(seg_pair_t s);
         pending.push_back(compute(s));
      endfunction

      function void check_crossing(crossing_t got);
         crossing_t want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: hit=%0b pv=%0b x=%0d y=%0d",
                        got.hit, got.point_valid, got.px, got.py);
            return;
         end
         want = pending.pop_front();
         if (got.hit !== want.hit || got.point_valid !== want.point_valid ||
             got.px !== want.px || got.py !== want.py) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp hit=%0b pv=%0b x=%0d y=%0d, got hit=%0b pv=%0b x=%0d y=%0d",
                        want.hit, want.point_valid, want.px, want.py,
                        got.hit, got.point_valid, got.px, got.py);
         end
      endfunction
   endclass

   logic   clock = 0;
   logic   reset = 1;
   logic   req_valid = 0;
   logic   req_ready;
   coord_t req_a_start_x = '0, req_a_start_y = '0, req_a_end_x = '0, req_a_end_y = '0;
   coord_t req_b_start_x = '0, req_b_start_y = '0, req_b_end_x = '0, req_b_end_y = '0;
   logic   rsp_valid;
   logic   rsp_ready = 0;
   logic   rsp_hit, rsp_point_valid;
   coord_t rsp_point_x, rsp_point_y;

   crossing_board board = new();
   int            cycle_count = 0;
   bit            stim_done = 0;

   always #5 clock = ~clock;

   segment_intersection_point_core u_dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_a_start_x, .req_a_start_y, .req_a_end_x, .req_a_end_y,
      .req_b_start_x, .req_b_start_y, .req_b_end_x, .req_b_end_y,
      .rsp_valid, .rsp_ready, .rsp_hit, .rsp_point_valid, .rsp_point_x, .rsp_point_y
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side: sample at rising edge, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_crossing('{rsp_hit, rsp_point_valid, rsp_point_x, rsp_point_y});
   end

   initial begin : rsp_stall
      int g;
      @(negedge clock);
      forever begin
         g = gap_len();
         if (g == 0 || $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1;
            @(negedge clock);
         end else begin
            rsp_ready <= 0;
            repeat (g) @(negedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // present one item at the falling edge and hold it until accepted
   task automatic send_pair(seg_pair_t s);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1;
      req_a_start_x <= s.asx; req_a_start_y <= s.asy;
      req_a_end_x <= s.aex; req_a_end_y <= s.aey;
      req_b_start_x <= s.bsx; req_b_start_y <= s.bsy;
      req_b_end_x <= s.bex; req_b_end_y <= s.bey;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_pair(s);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   function automatic coord_t rand_coord(int mode);
      case (mode)
         0: return coord_t'($urandom());
         1: return coord_t'($signed($urandom_range(0, 40)) - 20);
         default: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   function automatic seg_pair_t rand_pair();
      seg_pair_t s;
      int        m;
      int        k;
      m = $urandom_range(0, 2);
      k = $urandom_range(0, 9);
      s.asx = rand_coord(m); s.asy = rand_coord(m);
      s.aex = rand_coord(m); s.aey = rand_coord(m);
      s.bsx = rand_coord(m); s.bsy = rand_coord(m);
      s.bex = rand_coord(m); s.bey = rand_coord(m);
      // crossing pairs: B spans A's box in opposite direction
      if (k < 5) begin
         s.bsx = s.asx; s.bsy = s.aey;
         s.bex = s.aex; s.bey = s.asy;
      end else if (k == 5) begin
         // parallel copy of A
         s.bsx = s.asx; s.bsy = s.asy; s.bex = s.aex; s.bey = s.aey;
      end
      return s;
   endfunction

   localparam coord_t CMAX = coord_t'((1 << (CW - 1)) - 1);
   localparam coord_t CMIN = coord_t'(1 << (CW - 1));

   initial begin : stimulus
      seg_pair_t directed[$];
      directed.push_back('{0, 0, 10, 10, 0, 10, 10, 0});           // plain cross
      directed.push_back('{0, 0, 1, 1, 5, 5, 6, 6});               // boxes apart
      directed.push_back('{0, 0, 10, 10, 2, 2, 8, 8});             // parallel overlap
      directed.push_back('{3, 3, 3, 3, 3, 3, 3, 3});               // points
      directed.push_back('{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN});
      directed.push_back('{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX});
      directed.push_back('{CMIN, 0, CMAX, 1, CMIN, 1, CMAX, 0});   // near-parallel, shallow crossing
      directed.push_back('{CMIN, CMIN, CMIN, CMAX, CMIN, 0, CMAX, 0});
      directed.push_back('{-1, -1, -1, -1, -1, -1, -1, -1});
      directed.push_back('{0, 0, 7, 3, 1, 2, 6, 0});               // truncating point
      directed.push_back('{0, 0, 10, 0, 0, 0, 0, 10});             // shared endpoint
      directed.push_back('{-5, 7, 9, -3, -8, -6, 4, 11});
      directed.push_back('{0, 0, 4, 1, 0, 1, 4, 0});
      directed.push_back('{CMAX, 0, CMAX, 5, 0, 2, CMAX, 3});
      directed.push_back('{0, CMIN, 0, CMAX, CMIN, CMIN, CMAX, CMAX});
      repeat (7) @(posedge clock);
      reset <= 0;
      @(negedge clock);
      foreach (directed[i]) send_pair(directed[i]);
      for (int n = 0; n < ITEM_COUNT; n++) begin
         if (n == ITEM_COUNT / 2) wait_drained();
         send_pair(rand_pair());
      end
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin : finish_run
      wait (stim_done);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/sip_pkg.sv
rtl/sip_front.sv
rtl/sip_cell.sv
rtl/sip_out.sv
rtl/segment_intersection_point_core.sv
test/segment_intersection_point_core_test.sv
